@@ hdl/ast_pkg.sv @@
`timescale 1ns / 1ps

package ast_pkg;

  // series length
  localparam int MAX_TERMS = 32;
  localparam int NUM_CELLS = MAX_TERMS - 1;
  localparam int CNT_W     = $clog2(MAX_TERMS + 1);

  // term count register
  localparam int              TC_W     = 6;
  localparam logic [TC_W-1:0] TC_RESET = TC_W'(8);

  // argument and internal number formats
  localparam int X_W    = 16;
  localparam int FRAC_X = 15;
  localparam int Q_W    = 32;
  localparam int FRAC_W = 30;
  localparam int SUM_W  = 34;

  // result format
  localparam int OUT_W     = 18;
  localparam int RES_SHIFT = 14;
  localparam int RES_W     = SUM_W - RES_SHIFT;

  localparam logic signed [Q_W-1:0]     ONE_Q30  = Q_W'(1) << FRAC_W;
  localparam logic signed [2*Q_W-1:0]   RND_HALF = (2 * Q_W)'(1) << (FRAC_W - 1);
  localparam logic signed [SUM_W-1:0]   RES_HALF = SUM_W'(1) << (RES_SHIFT - 1);
  localparam logic signed [RES_W-1:0]   RES_MAX  = RES_W'((1 << (OUT_W - 1)) - 1);
  localparam logic signed [RES_W-1:0]   RES_MIN  = RES_W'(-(1 << (OUT_W - 1)));

  // step of the shared multiplier inside every cell
  typedef enum logic [3:0] {
    PH_FCT   = 4'b0001,
    PH_NUM   = 4'b0010,
    PH_PROD  = 4'b0100,
    PH_SCALE = 4'b1000
  } phase_t;

  // what one cell hands to the next
  typedef struct packed {
    logic                    valid;
    logic signed [Q_W-1:0]   x2;
    logic signed [Q_W-1:0]   num;
    logic signed [Q_W-1:0]   fct;
    logic signed [SUM_W-1:0] sum;
    logic signed [Q_W-1:0]   term;
  } beat_t;

  // round half up and drop the 30 fraction bits of a product
  function automatic logic signed [Q_W-1:0] rnd_q30(input logic signed [2*Q_W-1:0] p);
    logic signed [2*Q_W-1:0] w;
    w = p + RND_HALF;
    return w[FRAC_W+Q_W-1:FRAC_W];
  endfunction

endpackage

@@ hdl/ast_cell.sv @@
`timescale 1ns / 1ps

module ast_cell (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         step,
  input  ast_pkg::phase_t              phase,
  input  logic                         active,
  input  logic signed [ast_pkg::Q_W-1:0] ratio,
  input  logic signed [ast_pkg::Q_W-1:0] recip,
  input  ast_pkg::beat_t               up,
  output ast_pkg::beat_t               down
);
  import ast_pkg::*;

  logic                    valid;
  logic signed [Q_W-1:0]   x2;
  logic signed [Q_W-1:0]   num;
  logic signed [Q_W-1:0]   fct;
  logic signed [SUM_W-1:0] sum;
  logic signed [Q_W-1:0]   term;

  logic signed [Q_W-1:0]   op_a;
  logic signed [Q_W-1:0]   op_b;
  logic signed [2*Q_W-1:0] prod;
  logic signed [Q_W-1:0]   prod_q;

  // operand select for the one multiplier
  always_comb begin
    case (phase)
      PH_FCT: begin
        op_a = fct;
        op_b = ratio;
      end
      PH_NUM: begin
        op_a = num;
        op_b = x2;
      end
      PH_PROD: begin
        op_a = fct;
        op_b = num;
      end
      PH_SCALE: begin
        op_a = term;
        op_b = recip;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign prod   = op_a * op_b;
  assign prod_q = rnd_q30(prod);

  // occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (step) begin
      valid <= up.valid;
    end
  end

  // load from upstream, then one multiply per phase
  always_ff @(posedge clk) begin
    if (step) begin
      x2   <= up.x2;
      num  <= up.num;
      fct  <= up.fct;
      sum  <= up.sum;
      term <= up.term;
    end else begin
      case (phase)
        PH_FCT: begin
          fct <= prod_q;
          sum <= sum + SUM_W'(term);
        end
        PH_NUM: begin
          num <= prod_q;
        end
        PH_PROD: begin
          term <= prod_q;
        end
        default: begin
        end
      endcase
    end
  end

  // the scaled term leaves straight from the multiplier
  always_comb begin
    down.valid = valid;
    down.x2    = x2;
    down.num   = num;
    down.fct   = fct;
    down.sum   = sum;
    down.term  = active ? prod_q : '0;
  end

endmodule

@@ hdl/ast_finish.sv @@
`timescale 1ns / 1ps

module ast_finish (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             step,
  input  ast_pkg::beat_t                   up,
  output logic                             busy,
  output logic signed [ast_pkg::OUT_W-1:0] arcsin_value,
  output logic                             arcsin_valid,
  input  logic                             arcsin_stall
);
  import ast_pkg::*;

  logic                    hold_valid;
  logic signed [SUM_W-1:0] hold_sum;
  logic signed [Q_W-1:0]   hold_term;

  logic signed [SUM_W-1:0] total;
  logic signed [RES_W-1:0] res;
  logic signed [RES_W-1:0] res_sat;
  logic                    out_free;

  assign out_free = !arcsin_valid || !arcsin_stall;
  assign busy     = hold_valid;

  // last term added, rounded to q2.16 and clipped
  assign total = hold_sum + SUM_W'(hold_term) + RES_HALF;
  assign res   = total[SUM_W-1:RES_SHIFT];

  always_comb begin
    if (res > RES_MAX) begin
      res_sat = RES_MAX;
    end else if (res < RES_MIN) begin
      res_sat = RES_MIN;
    end else begin
      res_sat = res;
    end
  end

  // holding slot control
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (step) begin
      hold_valid <= up.valid;
    end else if (out_free) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      hold_sum  <= up.sum;
      hold_term <= up.term;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      arcsin_valid <= 1'b0;
    end else if (out_free) begin
      arcsin_valid <= hold_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && hold_valid) begin
      arcsin_value <= res_sat[OUT_W-1:0];
    end
  end

endmodule

@@ hdl/arcsin_taylor_series.sv @@
`timescale 1ns / 1ps

// Arcsine of a Q1.15 argument by the truncated Maclaurin series, result in
// Q2.16 with saturation. The series runs down a chain of MAX_TERMS-1 cells,
// one cell per term after the first; each cell owns one 32x32 multiplier that
// it uses four times (coefficient ratio, power step, coefficient times power,
// scale by 1/(2i+1)), so the whole chain advances one cell at the end of each
// scale step, and a new argument can enter each time the chain advances.
// Every beat walks the full chain whatever term_count says. An argument
// passes the input register, every cell, and the holding slot and output
// register of the finishing stage; a stalled output holds the chain once
// the end slot is full. term_count is taken as 1 when written 0 and as
// MAX_TERMS when written above it; write it only while no beat is inside
// the block.
module arcsin_taylor_series (
  input  logic                              clk,
  input  logic                              rst,
  input  logic signed [ast_pkg::X_W-1:0]    x_value,
  input  logic                              x_valid,
  output logic                              x_stall,
  output logic signed [ast_pkg::OUT_W-1:0]  arcsin_value,
  output logic                              arcsin_valid,
  input  logic                              arcsin_stall,
  input  logic [ast_pkg::TC_W-1:0]          term_count,
  input  logic                              term_count_valid,
  output logic                              term_count_ready
);
  import ast_pkg::*;

  logic [TC_W-1:0]  tc;
  logic [CNT_W-1:0] n_eff;

  phase_t phase;
  phase_t phase_next;
  logic   step;
  logic   finish_busy;

  logic                  head_valid;
  logic signed [Q_W-1:0] head_x2;
  logic signed [Q_W-1:0] head_num;
  logic signed [2*X_W-1:0] x_sq;
  logic signed [Q_W-1:0] x_q30;
  logic                  accept;

  beat_t                 chain [NUM_CELLS+1];
  logic [NUM_CELLS-1:0]  cell_active;

  // configuration register, always ready
  assign term_count_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tc <= TC_RESET;
    end else if (term_count_valid && term_count_ready) begin
      tc <= term_count;
    end
  end

  // clamp term count to 1..MAX_TERMS
  always_ff @(posedge clk) begin
    if (tc == '0) begin
      n_eff <= CNT_W'(1);
    end else if (int'(tc) > MAX_TERMS) begin
      n_eff <= CNT_W'(MAX_TERMS);
    end else begin
      n_eff <= CNT_W'(tc);
    end
  end

  // shared phase sequencer, waits in the last phase while the end is full
  assign step = (phase == PH_SCALE) && !finish_busy;

  always_comb begin
    case (phase)
      PH_FCT:   phase_next = PH_NUM;
      PH_NUM:   phase_next = PH_PROD;
      PH_PROD:  phase_next = PH_SCALE;
      PH_SCALE: phase_next = step ? PH_FCT : PH_SCALE;
      default:  phase_next = PH_FCT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_FCT;
    end else begin
      phase <= phase_next;
    end
  end

  // input register: x squared and x in q2.30
  assign x_stall = head_valid && !step;
  assign accept  = x_valid && !x_stall;
  assign x_sq    = x_value * x_value;
  assign x_q30   = Q_W'(x_value) <<< (FRAC_W - FRAC_X);

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
    end else if (accept) begin
      head_valid <= 1'b1;
    end else if (step) begin
      head_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      head_x2  <= Q_W'(x_sq);
      head_num <= x_q30;
    end
  end

  // first term is x itself
  assign chain[0].valid = head_valid;
  assign chain[0].x2    = head_x2;
  assign chain[0].num   = head_num;
  assign chain[0].fct   = ONE_Q30;
  assign chain[0].sum   = SUM_W'(head_num);
  assign chain[0].term  = '0;

  // one cell per further term, ratio and reciprocal fixed per position
  for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
    localparam longint TI     = longint'(g + 1);
    localparam longint RA_DEN = 2 * TI;
    localparam longint RA_VAL = (((2 * TI - 1) <<< FRAC_W) + TI) / RA_DEN;
    localparam longint RD_DEN = 2 * TI + 1;
    localparam longint RD_VAL = ((longint'(1) <<< FRAC_W) + RD_DEN / 2) / RD_DEN;

    assign cell_active[g] = CNT_W'(g + 1) < n_eff;

    ast_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .step   (step),
      .phase  (phase),
      .active (cell_active[g]),
      .ratio  (Q_W'(RA_VAL)),
      .recip  (Q_W'(RD_VAL)),
      .up     (chain[g]),
      .down   (chain[g+1])
    );
  end

  // final add, rounding and output register
  ast_finish u_finish (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .up           (chain[NUM_CELLS]),
    .busy         (finish_busy),
    .arcsin_value (arcsin_value),
    .arcsin_valid (arcsin_valid),
    .arcsin_stall (arcsin_stall)
  );

endmodule
